// ===== rtl/amf0tp_pkg.sv =====
// amf0tp_pkg: types and codes shared by the AMF0 token parser.
// Parse phases, token kinds, marker bytes, parser state and result records.
// No dependencies.
package amf0tp_pkg;

  typedef enum logic [3:0] {
    PH_TOP         = 4'd0,
    PH_NUM         = 4'd1,
    PH_NUMFIX      = 4'd2,
    PH_BOOL        = 4'd3,
    PH_SLEN_HI     = 4'd4,
    PH_SLEN_LO     = 4'd5,
    PH_SBODY       = 4'd6,
    PH_KLEN_HI     = 4'd7,
    PH_KLEN_LO     = 4'd8,
    PH_KBODY       = 4'd9,
    PH_VALUE       = 4'd10,
    PH_AFTER_EMPTY = 4'd11
  } phase_e;

  typedef enum logic [2:0] {
    K_NUMBER   = 3'd0,
    K_BOOL     = 3'd1,
    K_STRBYTE  = 3'd2,
    K_KEYBYTE  = 3'd3,
    K_OBJSTART = 3'd4,
    K_OBJEND   = 3'd5,
    K_NULL     = 3'd6,
    K_MSGEND   = 3'd7
  } kind_e;

  localparam logic [7:0] MK_NUMBER   = 8'h00;
  localparam logic [7:0] MK_BOOL     = 8'h01;
  localparam logic [7:0] MK_STRING   = 8'h02;
  localparam logic [7:0] MK_OBJECT   = 8'h03;
  localparam logic [7:0] MK_NULL     = 8'h05;
  localparam logic [7:0] MK_OBJEND   = 8'h09;
  localparam logic [7:0] REPAIR_BYTE = 8'hC3;
  localparam logic [7:0] TRUE_BYTE   = 8'h01;

  typedef struct packed {
    phase_e       phase;
    logic [15:0]  remaining;
    logic [63:0]  shift;
    logic [2:0]   idx;
    logic [7:0]   len_hi;
    logic         in_obj;
    logic [7:0]   num_cnt;
    logic [7:0]   str_cnt;
    logic [7:0]   bool_cnt;
    logic [15:0]  repair;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:     PH_TOP,
    remaining: 16'd0,
    shift:     64'd0,
    idx:       3'd0,
    len_hi:    8'd0,
    in_obj:    1'b0,
    num_cnt:   8'd0,
    str_cnt:   8'd0,
    bool_cnt:  8'd0,
    repair:    16'd0
  };

  typedef struct packed {
    kind_e        kind;
    logic [63:0]  value;
    logic         empty;
    logic         tend;
    logic         obj;
    logic [7:0]   ord;
    logic         trunc;
    logic         last;
  } result_t;

  // results of one byte: up to two, first goes out before second
  typedef struct packed {
    logic    first_v;
    result_t first;
    logic    second_v;
    result_t second;
  } step_out_t;

endpackage

// ===== rtl/amf0tp_if.sv =====
// amf0tp_in_if / amf0tp_out_if: valid/ready channels of the AMF0 token parser.
// Byte input channel and token output channel. No dependencies.
interface amf0tp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, end_of_message, output ready);
endinterface

interface amf0tp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [63:0] token_value;
  logic        empty_text;
  logic        text_end;
  logic        inside_object;
  logic [7:0]  type_ordinal;
  logic        truncated;
  logic        last_result;

  modport source (output valid, token_kind, token_value, empty_text, text_end,
                  inside_object, type_ordinal, truncated, last_result,
                  input ready);
  modport sink (input valid, token_kind, token_value, empty_text, text_end,
                inside_object, type_ordinal, truncated, last_result,
                output ready);
endinterface

// ===== rtl/amf0tp_step.sv =====
// amf0tp_step: one-byte parse step of the AMF0 token parser.
// Combinational next state and results from current state and byte.
// Depends on amf0tp_pkg.
module amf0tp_step
  import amf0tp_pkg::*;
(
  input  state_t     st_i,
  input  logic [7:0] byte_i,
  input  logic       eom_i,
  output state_t     nxt_o,
  output step_out_t  res_o
);

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  state_t      nxt;
  result_t     tok;
  result_t     msg;
  logic        tok_v;
  logic        marker;
  logic        finish;
  logic [15:0] len;
  logic [15:0] rem;
  phase_e      after_ph;

  always_comb begin
    nxt      = st_i;
    tok      = '0;
    tok_v    = 1'b0;
    marker   = 1'b0;
    finish   = 1'b0;
    len      = {st_i.len_hi, byte_i};
    rem      = st_i.remaining - 16'd1;
    after_ph = st_i.in_obj ? PH_KLEN_HI : PH_TOP;

    unique case (st_i.phase)
      PH_TOP, PH_VALUE: marker = 1'b1;
      PH_AFTER_EMPTY: begin
        if (byte_i == MK_OBJEND) begin
          tok_v      = 1'b1;
          tok.kind   = K_OBJEND;
          tok.obj    = 1'b1;
          nxt.in_obj = 1'b0;
          nxt.phase  = PH_TOP;
        end else begin
          marker = 1'b1;
        end
      end
      PH_NUM: begin
        if (st_i.idx != 3'd7) begin
          nxt.shift = {st_i.shift[55:0], byte_i};
          nxt.idx   = st_i.idx + 3'd1;
        end else if (byte_i == REPAIR_BYTE) begin
          // drop the corrupted byte, the next one stands in for it
          nxt.repair = sat_inc16(st_i.repair);
          nxt.phase  = PH_NUMFIX;
        end else begin
          finish = 1'b1;
        end
      end
      PH_NUMFIX: finish = 1'b1;
      PH_BOOL: begin
        tok_v     = 1'b1;
        tok.kind  = K_BOOL;
        tok.value = {63'd0, byte_i == TRUE_BYTE};
        tok.obj   = st_i.in_obj;
        tok.ord   = st_i.in_obj ? 8'd0 : st_i.bool_cnt;
        if (!st_i.in_obj) nxt.bool_cnt = sat_inc8(st_i.bool_cnt);
        nxt.phase = after_ph;
      end
      PH_SLEN_HI: begin
        nxt.len_hi = byte_i;
        nxt.phase  = PH_SLEN_LO;
      end
      PH_KLEN_HI: begin
        nxt.len_hi = byte_i;
        nxt.phase  = PH_KLEN_LO;
      end
      PH_SLEN_LO: begin
        if (len == 16'd0) begin
          tok_v     = 1'b1;
          tok.kind  = K_STRBYTE;
          tok.empty = 1'b1;
          tok.tend  = 1'b1;
          tok.obj   = st_i.in_obj;
          tok.ord   = st_i.in_obj ? 8'd0 : st_i.str_cnt;
          if (!st_i.in_obj) nxt.str_cnt = sat_inc8(st_i.str_cnt);
          nxt.phase = after_ph;
        end else begin
          nxt.remaining = len;
          nxt.phase     = PH_SBODY;
        end
      end
      PH_KLEN_LO: begin
        if (len == 16'd0) begin
          tok_v     = 1'b1;
          tok.kind  = K_KEYBYTE;
          tok.empty = 1'b1;
          tok.tend  = 1'b1;
          tok.obj   = 1'b1;
          nxt.phase = PH_AFTER_EMPTY;
        end else begin
          nxt.remaining = len;
          nxt.phase     = PH_KBODY;
        end
      end
      PH_SBODY: begin
        nxt.remaining = rem;
        tok_v         = 1'b1;
        tok.kind      = K_STRBYTE;
        tok.value     = {56'd0, byte_i};
        tok.tend      = (rem == 16'd0);
        tok.obj       = st_i.in_obj;
        tok.ord       = st_i.in_obj ? 8'd0 : st_i.str_cnt;
        if (rem == 16'd0) begin
          if (!st_i.in_obj) nxt.str_cnt = sat_inc8(st_i.str_cnt);
          nxt.phase = after_ph;
        end
      end
      PH_KBODY: begin
        nxt.remaining = rem;
        tok_v         = 1'b1;
        tok.kind      = K_KEYBYTE;
        tok.value     = {56'd0, byte_i};
        tok.tend      = (rem == 16'd0);
        tok.obj       = 1'b1;
        if (rem == 16'd0) nxt.phase = PH_VALUE;
      end
      default: nxt.phase = PH_TOP;
    endcase

    if (finish) begin
      tok_v       = 1'b1;
      tok.kind    = K_NUMBER;
      tok.value   = {st_i.shift[55:0], byte_i};
      tok.obj     = st_i.in_obj;
      tok.ord     = st_i.in_obj ? 8'd0 : st_i.num_cnt;
      if (!st_i.in_obj) nxt.num_cnt = sat_inc8(st_i.num_cnt);
      nxt.shift   = 64'd0;
      nxt.idx     = 3'd0;
      nxt.phase   = after_ph;
    end

    if (marker) begin
      unique case (byte_i)
        MK_NUMBER: begin
          nxt.phase = PH_NUM;
          nxt.idx   = 3'd0;
          nxt.shift = 64'd0;
        end
        MK_BOOL:   nxt.phase = PH_BOOL;
        MK_STRING: nxt.phase = PH_SLEN_HI;
        MK_OBJECT: begin
          // nested objects are skipped like unknown markers
          if (!st_i.in_obj) begin
            tok_v      = 1'b1;
            tok.kind   = K_OBJSTART;
            nxt.in_obj = 1'b1;
            nxt.phase  = PH_KLEN_HI;
          end else begin
            nxt.phase = after_ph;
          end
        end
        MK_NULL: begin
          tok_v     = 1'b1;
          tok.kind  = K_NULL;
          tok.obj   = st_i.in_obj;
          nxt.phase = after_ph;
        end
        default: nxt.phase = after_ph;
      endcase
    end

    msg       = '0;
    msg.kind  = K_MSGEND;
    msg.value = {48'd0, nxt.repair};
    msg.trunc = (nxt.phase != PH_TOP) || nxt.in_obj;
    msg.last  = 1'b1;
    tok.last  = !eom_i;

    if (eom_i) nxt = STATE_RESET;

    res_o.first_v  = tok_v || eom_i;
    res_o.first    = tok_v ? tok : msg;
    res_o.second_v = tok_v && eom_i;
    res_o.second   = msg;
    nxt_o          = nxt;
  end

endmodule

// ===== rtl/amf0_token_parser.sv =====
// amf0_token_parser: streaming AMF0 tokenizer, one message byte per transaction.
// The first token of a byte is registered on the output in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the output is not stalled; a final byte that also closes
// a token yields two tokens and holds the input until the first is taken (one output port).
// Reset (rst_ni low, asynchronous): parser state cleared, output queue empty.
// Depends on amf0tp_pkg, amf0tp_in_if, amf0tp_out_if and amf0tp_step.
module amf0_token_parser
  import amf0tp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  amf0tp_in_if.sink     in_i,
  amf0tp_out_if.source  out_o
);

  state_t    st_q;
  state_t    st_d;
  step_out_t step;
  result_t   out_q, out_d;
  result_t   pend_q, pend_d;
  logic      out_valid_q, out_valid_d;
  logic      pend_valid_q, pend_valid_d;
  logic      accept;
  logic      take;

  amf0tp_step u_step (
    .st_i   (st_q),
    .byte_i (in_i.data_byte),
    .eom_i  (in_i.end_of_message),
    .nxt_o  (st_d),
    .res_o  (step)
  );

  assign take       = out_valid_q && out_o.ready;
  assign in_i.ready = !pend_valid_q && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    pend_d       = pend_q;
    if (accept) begin
      out_valid_d  = step.first_v;
      out_d        = step.first;
      pend_valid_d = step.second_v;
      pend_d       = step.second;
    end else if (take) begin
      out_valid_d  = pend_valid_q;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= STATE_RESET;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (accept) st_q <= st_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.token_kind    = out_q.kind;
  assign out_o.token_value   = out_q.value;
  assign out_o.empty_text    = out_q.empty;
  assign out_o.text_end      = out_q.tend;
  assign out_o.inside_object = out_q.obj;
  assign out_o.type_ordinal  = out_q.ord;
  assign out_o.truncated     = out_q.trunc;
  assign out_o.last_result   = out_q.last;

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking test of amf0_token_parser, byte channel in, token channel out.
// A token predictor runs alongside the parser; every accepted token is compared in order.
// Depends on amf0tp_pkg, amf0tp_in_if, amf0tp_out_if and the RTL of amf0_token_parser.
module testbench;
  import amf0tp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_BYTES = 700;

  logic clk;
  logic rst_n;

  amf0tp_in_if  byte_ch ();
  amf0tp_out_if tok_ch ();

  amf0_token_parser u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (tok_ch)
  );

  state_t      parse_st;
  result_t     byte_tokens[$];
  result_t     pending_tokens[$];
  logic [7:0]  msg_bytes[$];
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned stall_cycles;
  bit          idle_on;
  bit          hold_tokens;
  bit          hold_active;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] bump(input logic [7:0] cnt);
    return (cnt == 8'hFF) ? cnt : cnt + 8'd1;
  endfunction

  function automatic void add_token(input kind_e kind, input logic [63:0] value,
                                    input logic empty, input logic tend,
                                    input logic obj, input logic [7:0] ord,
                                    input logic trunc);
    result_t tok;
    tok.kind  = kind;
    tok.value = value;
    tok.empty = empty;
    tok.tend  = tend;
    tok.obj   = obj;
    tok.ord   = ord;
    tok.trunc = trunc;
    tok.last  = 1'b0;
    byte_tokens.push_back(tok);
  endfunction

  function automatic void value_done();
    parse_st.phase = parse_st.in_obj ? PH_KLEN_HI : PH_TOP;
  endfunction

  function automatic void take_marker(input logic [7:0] b);
    if (b == MK_NUMBER) begin
      parse_st.phase = PH_NUM;
      parse_st.idx   = 3'd0;
      parse_st.shift = 64'd0;
    end else if (b == MK_BOOL) begin
      parse_st.phase = PH_BOOL;
    end else if (b == MK_STRING) begin
      parse_st.phase = PH_SLEN_HI;
    end else if (b == MK_OBJECT && !parse_st.in_obj) begin
      add_token(K_OBJSTART, 64'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
      parse_st.in_obj = 1'b1;
      parse_st.phase  = PH_KLEN_HI;
    end else if (b == MK_NULL) begin
      add_token(K_NULL, 64'd0, 1'b0, 1'b0, parse_st.in_obj, 8'd0, 1'b0);
      value_done();
    end else begin
      // unknown marker (nested object included): skipped
      value_done();
    end
  endfunction

  function automatic void finish_number(input logic [7:0] b);
    parse_st.shift = {parse_st.shift[55:0], b};
    add_token(K_NUMBER, parse_st.shift, 1'b0, 1'b0, parse_st.in_obj,
              parse_st.in_obj ? 8'd0 : parse_st.num_cnt, 1'b0);
    if (!parse_st.in_obj) parse_st.num_cnt = bump(parse_st.num_cnt);
    parse_st.shift = 64'd0;
    parse_st.idx   = 3'd0;
    value_done();
  endfunction

  function automatic void predict_tokens(input logic [7:0] b, input logic eom);
    logic [15:0] text_len;
    byte_tokens.delete();
    case (parse_st.phase)
      PH_TOP, PH_VALUE: begin
        take_marker(b);
      end
      PH_AFTER_EMPTY: begin
        if (b == MK_OBJEND) begin
          add_token(K_OBJEND, 64'd0, 1'b0, 1'b0, 1'b1, 8'd0, 1'b0);
          parse_st.in_obj = 1'b0;
          parse_st.phase  = PH_TOP;
        end else begin
          take_marker(b);
        end
      end
      PH_NUM: begin
        if (parse_st.idx < 3'd7) begin
          parse_st.shift = {parse_st.shift[55:0], b};
          parse_st.idx   = parse_st.idx + 3'd1;
        end else if (b == REPAIR_BYTE) begin
          if (parse_st.repair != 16'hFFFF) parse_st.repair = parse_st.repair + 16'd1;
          parse_st.phase = PH_NUMFIX;
        end else begin
          finish_number(b);
        end
      end
      PH_NUMFIX: begin
        finish_number(b);
      end
      PH_BOOL: begin
        add_token(K_BOOL, {63'd0, b == TRUE_BYTE}, 1'b0, 1'b0, parse_st.in_obj,
                  parse_st.in_obj ? 8'd0 : parse_st.bool_cnt, 1'b0);
        if (!parse_st.in_obj) parse_st.bool_cnt = bump(parse_st.bool_cnt);
        value_done();
      end
      PH_SLEN_HI: begin
        parse_st.len_hi = b;
        parse_st.phase  = PH_SLEN_LO;
      end
      PH_KLEN_HI: begin
        parse_st.len_hi = b;
        parse_st.phase  = PH_KLEN_LO;
      end
      PH_SLEN_LO: begin
        text_len = {parse_st.len_hi, b};
        if (text_len == 16'd0) begin
          add_token(K_STRBYTE, 64'd0, 1'b1, 1'b1, parse_st.in_obj,
                    parse_st.in_obj ? 8'd0 : parse_st.str_cnt, 1'b0);
          if (!parse_st.in_obj) parse_st.str_cnt = bump(parse_st.str_cnt);
          value_done();
        end else begin
          parse_st.remaining = text_len;
          parse_st.phase     = PH_SBODY;
        end
      end
      PH_KLEN_LO: begin
        text_len = {parse_st.len_hi, b};
        if (text_len == 16'd0) begin
          add_token(K_KEYBYTE, 64'd0, 1'b1, 1'b1, 1'b1, 8'd0, 1'b0);
          parse_st.phase = PH_AFTER_EMPTY;
        end else begin
          parse_st.remaining = text_len;
          parse_st.phase     = PH_KBODY;
        end
      end
      PH_SBODY: begin
        parse_st.remaining = parse_st.remaining - 16'd1;
        add_token(K_STRBYTE, {56'd0, b}, 1'b0, parse_st.remaining == 16'd0,
                  parse_st.in_obj, parse_st.in_obj ? 8'd0 : parse_st.str_cnt, 1'b0);
        if (parse_st.remaining == 16'd0) begin
          if (!parse_st.in_obj) parse_st.str_cnt = bump(parse_st.str_cnt);
          value_done();
        end
      end
      PH_KBODY: begin
        parse_st.remaining = parse_st.remaining - 16'd1;
        add_token(K_KEYBYTE, {56'd0, b}, 1'b0, parse_st.remaining == 16'd0, 1'b1,
                  8'd0, 1'b0);
        if (parse_st.remaining == 16'd0) parse_st.phase = PH_VALUE;
      end
      default: begin
        parse_st.phase = PH_TOP;
      end
    endcase
    if (eom) begin
      add_token(K_MSGEND, {48'd0, parse_st.repair}, 1'b0, 1'b0, 1'b0, 8'd0,
                parse_st.phase != PH_TOP || parse_st.in_obj);
      parse_st = STATE_RESET;
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
    foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
  endfunction

  // ---------------------------------------------------------------- message builders

  function automatic void put_number(input logic [63:0] bits, input bit repair);
    msg_bytes.push_back(MK_NUMBER);
    for (int i = 7; i >= 1; i--) msg_bytes.push_back(bits[i*8 +: 8]);
    // a final byte equal to the repair byte must itself be preceded by one
    if (repair || bits[7:0] == REPAIR_BYTE) msg_bytes.push_back(REPAIR_BYTE);
    msg_bytes.push_back(bits[7:0]);
  endfunction

  function automatic void put_bool(input logic [7:0] b);
    msg_bytes.push_back(MK_BOOL);
    msg_bytes.push_back(b);
  endfunction

  // length and body; used for keys directly and for strings after the marker
  function automatic void put_text(input logic [15:0] text_len);
    msg_bytes.push_back(text_len[15:8]);
    msg_bytes.push_back(text_len[7:0]);
    for (int i = 0; i < int'(text_len); i++) msg_bytes.push_back($urandom_range(0, 255));
  endfunction

  function automatic void put_string(input logic [15:0] text_len);
    msg_bytes.push_back(MK_STRING);
    put_text(text_len);
  endfunction

  function automatic logic [15:0] random_len();
    if ($urandom_range(0, 19) == 0) return 16'd256 + 16'($urandom_range(0, 3));
    return 16'($urandom_range(0, 6));
  endfunction

  function automatic void put_unknown(input bit in_obj);
    logic [7:0] m;
    do begin
      m = $urandom_range(0, 255);
    end while (m == MK_NUMBER || m == MK_BOOL || m == MK_STRING || m == MK_NULL ||
               (!in_obj && m == MK_OBJECT));
    msg_bytes.push_back(m);
  endfunction

  function automatic void put_random_value(input bit in_obj);
    case ($urandom_range(0, 9))
      0, 1, 2: put_number({$urandom, $urandom}, $urandom_range(0, 3) == 0);
      3, 4:    put_bool($urandom_range(0, 1) ? TRUE_BYTE : 8'($urandom_range(0, 255)));
      5, 6:    put_string(random_len());
      7:       msg_bytes.push_back(MK_NULL);
      8: begin
        if (in_obj) put_unknown(in_obj);
        else put_random_object();
      end
      default: put_unknown(in_obj);
    endcase
  endfunction

  function automatic void put_random_object();
    int unsigned props;
    msg_bytes.push_back(MK_OBJECT);
    props = $urandom_range(0, 4);
    repeat (props) begin
      put_text(16'($urandom_range(0, 5)));
      put_random_value(1'b1);
    end
    if ($urandom_range(0, 7) != 0) begin
      msg_bytes.push_back(8'h00);
      msg_bytes.push_back(8'h00);
      msg_bytes.push_back(MK_OBJEND);
    end
  endfunction

  function automatic void build_random_message();
    int unsigned pick;
    int unsigned keep;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      repeat ($urandom_range(1, 10)) msg_bytes.push_back($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(1, 5)) put_random_value(1'b0);
      if (pick <= 3) begin
        keep = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
      end
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid          <= 1'b1;
    byte_ch.data_byte      <= b;
    byte_ch.end_of_message <= eom;
    do @(posedge clk); while (!byte_ch.ready);
    predict_tokens(b, eom);
    bytes_sent++;
  endtask

  // sends the built bytes; close marks the last one as end of message
  task automatic send_msg(input bit close);
    int unsigned n;
    n = msg_bytes.size();
    for (int i = 0; i < int'(n); i++) send_byte(msg_bytes[i], close && i == int'(n) - 1);
    msg_bytes.delete();
  endtask

  initial begin
    tok_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_tokens) begin
        hold_active = 1'b1;
        tok_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_tokens = 1'b0;
        hold_active = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        tok_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        tok_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : token_check
    result_t got;
    result_t want;
    if (rst_n && tok_ch.valid && tok_ch.ready) begin
      got.kind  = kind_e'(tok_ch.token_kind);
      got.value = tok_ch.token_value;
      got.empty = tok_ch.empty_text;
      got.tend  = tok_ch.text_end;
      got.obj   = tok_ch.inside_object;
      got.ord   = tok_ch.type_ordinal;
      got.trunc = tok_ch.truncated;
      got.last  = tok_ch.last_result;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none, got kind %0d value %0h",
                 $time, got.kind, got.value);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 64'(want.kind), 64'(got.kind));
        check_field("token_value", want.value, got.value);
        check_field("empty_text", 64'(want.empty), 64'(got.empty));
        check_field("text_end", 64'(want.tend), 64'(got.tend));
        check_field("inside_object", 64'(want.obj), 64'(got.obj));
        check_field("type_ordinal", 64'(want.ord), 64'(got.ord));
        check_field("truncated", 64'(want.trunc), 64'(got.trunc));
        check_field("last_result", 64'(want.last), 64'(got.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d tokens outstanding",
                 $time, STALL_LIMIT, pending_tokens.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_top_values();
    put_number(64'h0, 1'b0);
    put_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    put_bool(TRUE_BYTE);
    put_bool(8'h00);
    put_bool(8'hFF);
    put_string(16'd0);
    msg_bytes.push_back(MK_STRING);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h02);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(MK_NULL);   // null and message end on one byte
    send_msg(1'b1);
  endtask

  task automatic test_object();
    msg_bytes.push_back(MK_OBJECT);
    put_text(16'd1);
    put_number({$urandom, $urandom}, 1'b0);
    put_text(16'd0);                // empty key followed by a value
    put_bool(TRUE_BYTE);
    put_text(16'd2);
    msg_bytes.push_back(MK_NULL);
    put_text(16'd1);
    put_string(16'd0);
    put_text(16'd1);
    msg_bytes.push_back(MK_OBJECT); // nested object marker is skipped
    put_text(16'd1);
    msg_bytes.push_back(MK_OBJEND); // end marker after a named key is skipped
    put_text(16'd0);
    msg_bytes.push_back(MK_OBJECT);
    put_text(16'd0);
    msg_bytes.push_back(MK_OBJEND);
    msg_bytes.push_back(MK_OBJECT);
    put_text(16'd0);
    msg_bytes.push_back(MK_OBJEND); // object end and message end together
    send_msg(1'b1);
  endtask

  task automatic test_number_repair();
    logic [63:0] bits;
    put_number({$urandom, $urandom}, 1'b1);
    bits = {$urandom, $urandom};
    bits[7:0] = REPAIR_BYTE;
    put_number(bits, 1'b0);
    send_msg(1'b1);
    // message stops right on the dropped byte
    msg_bytes.push_back(MK_NUMBER);
    repeat (7) msg_bytes.push_back($urandom_range(0, 255));
    msg_bytes.push_back(REPAIR_BYTE);
    send_msg(1'b1);
    msg_bytes.push_back(MK_OBJECT);
    put_text(16'd1);
    put_number({$urandom, $urandom}, 1'b1);
    put_text(16'd0);
    msg_bytes.push_back(MK_OBJEND);
    send_msg(1'b1);
  endtask

  task automatic test_unknown_markers();
    msg_bytes.push_back(8'h04);
    msg_bytes.push_back(MK_OBJEND);
    msg_bytes.push_back(8'h06);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h80);
    msg_bytes.push_back(MK_NULL);
    send_msg(1'b1);
  endtask

  task automatic test_truncation();
    msg_bytes.push_back(MK_NUMBER);
    send_msg(1'b1);
    msg_bytes.push_back(MK_BOOL);
    send_msg(1'b1);
    msg_bytes.push_back(MK_STRING);
    msg_bytes.push_back(8'h00);
    send_msg(1'b1);
    msg_bytes.push_back(MK_STRING);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h03);
    msg_bytes.push_back(8'h41);
    send_msg(1'b1);
    msg_bytes.push_back(MK_OBJECT);
    send_msg(1'b1);
    msg_bytes.push_back(MK_OBJECT);
    put_text(16'd0);                // ends right after the empty key
    send_msg(1'b1);
    msg_bytes.push_back(MK_OBJECT);
    put_text(16'd1);
    put_bool(8'h01);                // complete property, object left open
    send_msg(1'b1);
    msg_bytes.push_back(8'h7F);     // lone unknown marker: not truncated
    send_msg(1'b1);
  endtask

  // boolean ordinal runs past 255 and sticks there
  task automatic test_ordinal_saturation();
    for (int i = 0; i < 258; i++) begin
      put_bool($urandom_range(0, 1) ? TRUE_BYTE : 8'($urandom_range(0, 255)));
    end
    put_string(16'd1);
    put_number({$urandom, $urandom}, 1'b0);
    send_msg(1'b1);
  endtask

  task automatic test_backpressure();
    hold_tokens = 1'b1;
    wait (hold_active);
    put_string(16'd40);
    put_number({$urandom, $urandom}, 1'b0);
    send_msg(1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      build_random_message();
      send_msg(1'b1);
    end
  endtask

  // largest length field, message cut short inside the body
  task automatic test_long_text();
    idle_on = 1'b0;
    msg_bytes.push_back(MK_STRING);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'hFF);
    repeat (6) msg_bytes.push_back(8'($urandom_range(0, 255)));
    send_msg(1'b1);
  endtask

  // one message with many repaired numbers; the count shows on message end
  task automatic test_repair_count();
    for (int i = 0; i < 20; i++) put_number({$urandom, $urandom}, 1'b1);
    send_msg(1'b1);
  endtask

  initial begin
    rst_n                  = 1'b0;
    byte_ch.valid          = 1'b0;
    byte_ch.data_byte      = 8'h00;
    byte_ch.end_of_message = 1'b0;
    parse_st               = STATE_RESET;
    mismatches             = 0;
    bytes_sent             = 0;
    stall_cycles           = 0;
    idle_on                = 1'b1;
    hold_tokens            = 1'b0;
    hold_active            = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_top_values();
    test_object();
    test_number_repair();
    test_unknown_markers();
    test_truncation();
    test_ordinal_saturation();
    test_backpressure();
    test_random_messages();
    test_long_text();
    test_repair_count();

    byte_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
